// ----- design/stip_pkg.sv -----
// ----------------------------------------------------------------------------
// stip_pkg
// Shared constants, types and character helpers for the string to integer
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stip_pkg;

  // string length limit and derived widths
  localparam int MAX_CHARS = 1024;
  localparam int POS_W     = $clog2(MAX_CHARS + 1);
  localparam int END_W     = 11;
  localparam int VALUE_W   = 64;
  localparam int BASE_W    = 6;
  localparam int DIG_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 1;

  // digit code for a byte that is no digit or letter
  localparam logic [DIG_W-1:0] NOT_DIGIT = 7'd99;

  // radix values
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  // register reset values
  localparam logic [BASE_W-1:0] RST_NUMBER_BASE   = BASE_DEC;
  localparam logic              RST_SIGNED_RESULT = 1'b1;

  // signed limits
  localparam logic [VALUE_W-1:0] SIGNED_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SIGNED_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_BASE   = 1'b0,
    CFG_SIGNED_RESULT = 1'b1
  } cfg_index_t;

  // parse phase
  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_ZEROX  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // raw outcome of one string, handed to the result stage
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               ovf;
    logic               neg;
    logic [POS_W-1:0]   num_end;
  } cand_t;

  // digit value of a byte, NOT_DIGIT when it has none
  function automatic logic [DIG_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIG_W-1:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIG_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIG_W'(c - CH_LA + LETTER_OFS);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIG_W'(c - CH_UA + LETTER_OFS);
    end else begin
      d = NOT_DIGIT;
    end
    return d;
  endfunction

  // space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

// ----- design/stip_mac.sv -----
// ----------------------------------------------------------------------------
// stip_mac
// Multiply-add of the accumulated value by the radix plus one digit, with a
// carry out that flags overflow of the 64-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_mac (
  input  wire logic [stip_pkg::VALUE_W-1:0] acc,
  input  wire logic [stip_pkg::BASE_W-1:0]  base,
  input  wire logic [stip_pkg::DIG_W-1:0]   digit,
  output logic      [stip_pkg::VALUE_W-1:0] sum,
  output logic                              carry
);

  localparam int PROD_W = stip_pkg::VALUE_W + stip_pkg::BASE_W;
  localparam int FULL_W = PROD_W + 1;

  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] full;

  // product and digit add, anything above bit 63 is an overflow
  assign prod  = PROD_W'(acc) * PROD_W'(base);
  assign full  = FULL_W'(prod) + FULL_W'(digit);
  assign sum   = full[stip_pkg::VALUE_W-1:0];
  assign carry = |full[FULL_W-1:stip_pkg::VALUE_W];

endmodule

`default_nettype wire

// ----- design/stip_step.sv -----
// ----------------------------------------------------------------------------
// stip_step
// Input register and per-character parse step: white space, sign, prefix
// detection and digit accumulation, one character a cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_step (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [stip_pkg::CHAR_W-1:0]         in_char_code,
  input  wire logic                                in_last_char,
  input  wire logic [stip_pkg::BASE_W-1:0]         number_base,
  output logic                                     cand_valid,
  input  wire logic                                cand_ready,
  output stip_pkg::cand_t                          cand
);

  // input register
  logic                          s1_valid_r;
  logic [stip_pkg::CHAR_W-1:0]   ch_r;
  logic                          last_r;
  logic                          go;

  // string state
  stip_pkg::phase_t              phase_r, phase_nxt;
  logic                          neg_r, neg_nxt;
  logic [stip_pkg::VALUE_W-1:0]  acc_r, acc_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [stip_pkg::BASE_W-1:0]   abase_r, abase_nxt;
  logic [stip_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [stip_pkg::POS_W-1:0]    end_r, end_nxt;

  // step datapath
  logic [stip_pkg::DIG_W-1:0]    dig;
  logic [stip_pkg::BASE_W-1:0]   mac_base;
  logic [stip_pkg::VALUE_W-1:0]  mac_sum;
  logic                          mac_carry;
  logic                          try_digit;
  logic                          take_ok;
  logic                          first_zero;
  logic [stip_pkg::BASE_W-1:0]   first_base;
  stip_pkg::phase_t              first_phase;

  // stall only when a final character meets a full result stage
  assign go       = s1_valid_r && (!last_r || cand_ready);
  assign in_ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r   <= in_char_code;
      last_r <= in_last_char;
    end
  end

  // digit decode and first-character radix choice
  assign dig        = stip_pkg::digit_of(ch_r);
  assign first_zero = (number_base == stip_pkg::BASE_AUTO ||
                       number_base == stip_pkg::BASE_HEX) && ch_r == stip_pkg::CH_0;
  always_comb begin
    if (first_zero) begin
      first_base = (number_base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT
                                                        : stip_pkg::BASE_HEX;
    end else begin
      first_base = (number_base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC
                                                        : number_base;
    end
  end

  assign take_ok     = try_digit && (dig < stip_pkg::DIG_W'(mac_base));
  assign first_phase = !take_ok ? stip_pkg::PH_DONE :
                       first_zero ? stip_pkg::PH_ZERO : stip_pkg::PH_DIGITS;

  stip_mac u_mac (
    .acc   (acc_r),
    .base  (mac_base),
    .digit (dig),
    .sum   (mac_sum),
    .carry (mac_carry)
  );

  // next state of the parse
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    abase_nxt = abase_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    end_nxt   = end_r;
    mac_base  = abase_r;
    try_digit = 1'b0;

    pos_nxt = (pos_r < stip_pkg::POS_W'(stip_pkg::MAX_CHARS)) ? pos_r + 1'b1 : pos_r;

    unique case (phase_r)
      stip_pkg::PH_SPACE: begin
        if (stip_pkg::is_space(ch_r)) begin
          phase_nxt = stip_pkg::PH_SPACE;
        end else if (ch_r == stip_pkg::CH_PLUS || ch_r == stip_pkg::CH_MINUS) begin
          neg_nxt   = (ch_r == stip_pkg::CH_MINUS);
          phase_nxt = stip_pkg::PH_SIGNED;
        end else begin
          mac_base  = first_base;
          abase_nxt = first_base;
          try_digit = 1'b1;
          phase_nxt = first_phase;
        end
      end
      stip_pkg::PH_SIGNED: begin
        mac_base  = first_base;
        abase_nxt = first_base;
        try_digit = 1'b1;
        phase_nxt = first_phase;
      end
      stip_pkg::PH_ZERO: begin
        if (ch_r == stip_pkg::CH_LX || ch_r == stip_pkg::CH_UX) begin
          phase_nxt = stip_pkg::PH_ZEROX;
        end else begin
          try_digit = 1'b1;
          phase_nxt = take_ok ? stip_pkg::PH_DIGITS : stip_pkg::PH_DONE;
        end
      end
      stip_pkg::PH_ZEROX: begin
        mac_base  = stip_pkg::BASE_HEX;
        try_digit = 1'b1;
        abase_nxt = take_ok ? stip_pkg::BASE_HEX : stip_pkg::BASE_AUTO;
        phase_nxt = take_ok ? stip_pkg::PH_DIGITS : stip_pkg::PH_DONE;
      end
      stip_pkg::PH_DIGITS: begin
        try_digit = 1'b1;
        phase_nxt = take_ok ? stip_pkg::PH_DIGITS : stip_pkg::PH_DONE;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // digit accepted: accumulate, sticky overflow, mark number end
    if (take_ok) begin
      acc_nxt = mac_sum;
      ovf_nxt = ovf_r | mac_carry;
      end_nxt = pos_nxt;
    end
  end

  // state register, cleared after the final character
  always_ff @(posedge clk) begin
    if (!rst_n || (go && last_r)) begin
      phase_r <= stip_pkg::PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      abase_r <= stip_pkg::BASE_AUTO;
      pos_r   <= '0;
      end_r   <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      abase_r <= abase_nxt;
      pos_r   <= pos_nxt;
      end_r   <= end_nxt;
    end
  end

  // outcome of the string on its final character
  assign cand_valid   = go && last_r;
  assign cand.acc     = acc_nxt;
  assign cand.ovf     = ovf_nxt;
  assign cand.neg     = neg_nxt;
  assign cand.num_end = end_nxt;

endmodule

`default_nettype wire

// ----- design/stip_finish.sv -----
// ----------------------------------------------------------------------------
// stip_finish
// Holds the outcome of a string, applies signed or unsigned range handling
// and presents the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_finish (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cand_valid,
  output logic                                 cand_ready,
  input  wire stip_pkg::cand_t                 cand,
  input  wire logic                            signed_result,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [stip_pkg::VALUE_W-1:0]         out_value,
  output logic [stip_pkg::END_W-1:0]           out_end_offset,
  output logic                                 out_range_error
);

  logic                          pend_valid_r;
  stip_pkg::cand_t               pend_r;
  logic                          out_valid_r;
  logic [stip_pkg::VALUE_W-1:0]  value_r, value_nxt;
  logic [stip_pkg::END_W-1:0]    end_off_r, end_off_nxt;
  logic                          rng_r, rng_nxt;
  logic                          out_load;
  logic [stip_pkg::VALUE_W-1:0]  lim;
  logic [stip_pkg::VALUE_W-1:0]  signed_val;

  assign out_load   = !out_valid_r || out_ready;
  assign cand_ready = !pend_valid_r || out_load;

  // pending outcome register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cand_ready) begin
      pend_valid_r <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_valid && cand_ready) begin
      pend_r <= cand;
    end
  end

  // clamp or wrap the value
  assign lim        = pend_r.neg ? stip_pkg::SIGNED_MIN : stip_pkg::SIGNED_MAX;
  assign signed_val = pend_r.neg ? (stip_pkg::VALUE_W'(0) - pend_r.acc) : pend_r.acc;

  always_comb begin
    value_nxt   = signed_val;
    rng_nxt     = 1'b0;
    end_off_nxt = stip_pkg::END_W'(pend_r.num_end);
    if (pend_r.num_end == '0) begin
      value_nxt = '0;
    end else if (signed_result) begin
      if (pend_r.ovf || pend_r.acc > lim) begin
        value_nxt = lim;
        rng_nxt   = 1'b1;
      end
    end else if (pend_r.ovf) begin
      value_nxt = '1;
      rng_nxt   = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r && out_load) begin
      value_r   <= value_nxt;
      end_off_r <= end_off_nxt;
      rng_r     <= rng_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = value_r;
  assign out_end_offset  = end_off_r;
  assign out_range_error = rng_r;

endmodule

`default_nettype wire

// ----- design/string_to_integer_parser.sv -----
// Path: input register, pending outcome register, then output register.
// Throughput: one character per cycle, limited by the digit multiply-add loop,
// but a final character stalls while the result stage is full.
// Reset: synchronous active-low; clears parse state and pipeline valids,
// number_base returns to 10 and signed_result to 1.
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Converts a byte stream to a 64-bit integer in strtoll / strtoull fashion,
// one result per string on its final character.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_integer_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [stip_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [stip_pkg::BASE_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [stip_pkg::CHAR_W-1:0]       in_char_code,
  input  wire logic                              in_last_char,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [stip_pkg::VALUE_W-1:0]           out_value,
  output logic [stip_pkg::END_W-1:0]             out_end_offset,
  output logic                                   out_range_error
);

  logic [stip_pkg::BASE_W-1:0]  number_base_r;
  logic                         signed_result_r;
  logic                         cand_valid;
  logic                         cand_ready;
  stip_pkg::cand_t              cand;

  // configuration registers, every write transfer is taken at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r   <= stip_pkg::RST_NUMBER_BASE;
      signed_result_r <= stip_pkg::RST_SIGNED_RESULT;
    end else if (cfg_valid) begin
      unique case (stip_pkg::cfg_index_t'(cfg_index))
        stip_pkg::CFG_NUMBER_BASE:   number_base_r   <= cfg_data;
        stip_pkg::CFG_SIGNED_RESULT: signed_result_r <= cfg_data[0];
        default:                     number_base_r   <= number_base_r;
      endcase
    end
  end

  // character step
  stip_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .number_base  (number_base_r),
    .cand_valid   (cand_valid),
    .cand_ready   (cand_ready),
    .cand         (cand)
  );

  // range handling and result register
  stip_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .cand_valid      (cand_valid),
    .cand_ready      (cand_ready),
    .cand            (cand),
    .signed_result   (signed_result_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_end_offset  (out_end_offset),
    .out_range_error (out_range_error)
  );

endmodule

`default_nettype wire
